// File: rtl/m68kadd_pkg.sv
// ----------------------------------------------------------------------------
// m68kadd_pkg
// Shared types and constants for the ADD execute block: size codes, masks,
// cycle costs and the result bundle passed from the ALU to the top level.
// ----------------------------------------------------------------------------
package m68kadd_pkg;

   // Register file geometry
   localparam int unsigned REG_COUNT = 8;
   localparam int unsigned REG_BITS  = 3;
   localparam int unsigned DATA_BITS = 32;

   // Operand masks per size
   localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
   localparam logic [31:0] WORD_MASK = 32'h0000_FFFF;
   localparam logic [31:0] LONG_MASK = 32'hFFFF_FFFF;

   // Base cycle costs
   localparam logic [7:0] CYC_SHORT_REG  = 8'd4;
   localparam logic [7:0] CYC_SHORT_MEM  = 8'd8;
   localparam logic [7:0] CYC_LONG_MEM   = 8'd12;
   localparam logic [7:0] CYC_LONG_DIRECT = 8'd8;
   localparam logic [7:0] CYC_LONG_OTHER = 8'd6;
   localparam logic [7:0] CYC_NO_OP      = 8'd1;
   localparam logic [7:0] CYC_MAX        = 8'd255;

   // EA modes that matter for the long form
   localparam logic [2:0] EA_MODE_DREG  = 3'd0;
   localparam logic [2:0] EA_MODE_AREG  = 3'd1;
   localparam logic [2:0] EA_MODE_OTHER = 3'd7;
   localparam logic [2:0] EA_REG_IMM    = 3'd4;

   // Size field of the opword
   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_WORD = 2'd1,
      SIZE_LONG = 2'd2,
      SIZE_NONE = 2'd3
   } size_type;

   // Item kind carried in tuser
   typedef enum logic {
      KIND_EXEC = 1'b0,
      KIND_LOAD = 1'b1
   } kind_type;

   // Result of one ADD, ALU to top level
   typedef struct packed {
      logic [31:0] sum;
      logic        to_ea;
      logic [4:0]  ccr;
      logic [7:0]  cycles;
      logic        performed;
      logic        reg_write;
      logic [31:0] reg_wdata;
   } alu_result_type;

endpackage

// File: rtl/m68kadd_alu.sv
// ----------------------------------------------------------------------------
// m68kadd_alu
// Opword decode, sized add with condition codes, cycle cost and register
// write-back value. Purely combinational; sits between the operand read
// register and the result register.
// ----------------------------------------------------------------------------
module m68kadd_alu (
   input  logic [15:0]                 op_word,
   input  logic [31:0]                 reg_operand,  // full data register
   input  logic [31:0]                 ea_operand,
   input  logic [7:0]                  ea_cycles,
   output m68kadd_pkg::alu_result_type result
);

   m68kadd_pkg::size_type size;
   logic        dir;
   logic [2:0]  ea_mode;
   logic [2:0]  ea_reg;
   logic [31:0] mask;
   logic [31:0] msb_mask;
   logic [31:0] opa;
   logic [31:0] opb;
   logic [32:0] sum_wide;
   logic [31:0] sum_r;
   logic        carry;
   logic        ovf;
   logic        neg;
   logic        zero;
   logic [7:0]  base;
   logic [8:0]  cyc_total;

   assign size    = m68kadd_pkg::size_type'(op_word[7:6]);
   assign dir     = op_word[8];
   assign ea_mode = op_word[5:3];
   assign ea_reg  = op_word[2:0];

   // Size dependent masks and sign-bit tap
   always_comb begin
      mask     = m68kadd_pkg::LONG_MASK;
      msb_mask = 32'h8000_0000;
      case (size)
         m68kadd_pkg::SIZE_BYTE: begin
            mask     = m68kadd_pkg::BYTE_MASK;
            msb_mask = 32'h0000_0080;
         end
         m68kadd_pkg::SIZE_WORD: begin
            mask     = m68kadd_pkg::WORD_MASK;
            msb_mask = 32'h0000_8000;
         end
         default: begin
            mask     = m68kadd_pkg::LONG_MASK;
            msb_mask = 32'h8000_0000;
         end
      endcase
   end

   // Sized add and flags
   assign opa      = reg_operand & mask;
   assign opb      = ea_operand & mask;
   assign sum_wide = {1'b0, opa} + {1'b0, opb};
   assign sum_r    = sum_wide[31:0] & mask;

   always_comb begin
      case (size)
         m68kadd_pkg::SIZE_BYTE: carry = sum_wide[8];
         m68kadd_pkg::SIZE_WORD: carry = sum_wide[16];
         default:                carry = sum_wide[32];
      endcase
   end

   assign ovf  = |((opa ^ sum_r) & (opb ^ sum_r) & msb_mask);
   assign neg  = |(sum_r & msb_mask);
   assign zero = (sum_r == 32'd0);

   // Base cycle cost
   always_comb begin
      if (size == m68kadd_pkg::SIZE_LONG) begin
         if (dir)
            base = m68kadd_pkg::CYC_LONG_MEM;
         else if (ea_mode == m68kadd_pkg::EA_MODE_DREG ||
                  ea_mode == m68kadd_pkg::EA_MODE_AREG ||
                  (ea_mode == m68kadd_pkg::EA_MODE_OTHER &&
                   ea_reg == m68kadd_pkg::EA_REG_IMM))
            base = m68kadd_pkg::CYC_LONG_DIRECT;
         else
            base = m68kadd_pkg::CYC_LONG_OTHER;
      end else begin
         base = dir ? m68kadd_pkg::CYC_SHORT_MEM : m68kadd_pkg::CYC_SHORT_REG;
      end
   end

   assign cyc_total = {1'b0, base} + {1'b0, ea_cycles};

   // Result bundle; size code 3 is a no-op costing one cycle
   always_comb begin
      result = '0;
      if (size == m68kadd_pkg::SIZE_NONE) begin
         result.cycles = m68kadd_pkg::CYC_NO_OP;
      end else begin
         result.sum       = sum_r;
         result.to_ea     = dir;
         result.ccr       = {carry, neg, zero, ovf, carry};
         result.cycles    = cyc_total[8] ? m68kadd_pkg::CYC_MAX : cyc_total[7:0];
         result.performed = 1'b1;
         result.reg_write = ~dir;
         result.reg_wdata = (reg_operand & ~mask) | sum_r;
      end
   end

endmodule

// File: rtl/m68kadd_execute_top.sv
// ----------------------------------------------------------------------------
// m68k_add_execute_top
// Executes 68000 ADD opwords against an eight-entry data register file held
// in a synchronous RAM, or presets a register in load mode.
// ----------------------------------------------------------------------------
//  Channel | Ports  | tuser          | tdata (low bit first)
//  --------+--------+----------------+----------------------------------------
//  request | req_*  | mode           | op_word, ea_operand, ea_cycles,
//          |        |                | load_index, load_value, zero pad
//  result  | rsp_*  | op_performed   | sum_value, sum_to_ea, ccr_flags,
//          |        |                | cycle_count, zero pad
//
//  One word per cycle unless the result stalls. Accepting a request reads
//  the register file RAM; the execute stage then adds and writes back.
//  Back-to-back hits on the same register are forwarded around the RAM.
//  Synchronous reset clears all per-entry valid bits; unwritten entries read 0.
//  A stalled result holds the execute stage, which holds the request side.
// ----------------------------------------------------------------------------
module m68k_add_execute_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // op_word, ea_operand, ea_cycles, load_index,
                                   // load_value, pad
   input  logic        req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // sum_value, sum_to_ea, ccr_flags,
                                   // cycle_count, pad
   output logic        rsp_tuser   // op_performed
);

   localparam int unsigned NREG = m68kadd_pkg::REG_COUNT;
   localparam int unsigned RB   = m68kadd_pkg::REG_BITS;
   localparam int unsigned DB   = m68kadd_pkg::DATA_BITS;

   // Register file RAM
   logic [DB-1:0]   regfile [NREG];
   logic [NREG-1:0] valid_ff, valid_in;

   // Execute stage
   logic                  s1_valid_ff, s1_valid_in;
   m68kadd_pkg::kind_type s1_kind_ff;
   logic [15:0]           s1_op_ff;
   logic [31:0]           s1_ea_ff;
   logic [7:0]            s1_cyc_ff;
   logic [RB-1:0]         s1_lidx_ff;
   logic [31:0]           s1_lval_ff;
   logic [DB-1:0]         rd_data_ff;
   logic                  rd_valid_ff;
   logic                  fwd_ff;
   logic [DB-1:0]         fwd_data_ff;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff;
   logic        rsp_user_ff;

   logic                       req_fire;
   logic                       s1_advance;
   logic [RB-1:0]              rd_addr;
   logic [DB-1:0]              reg_operand;
   m68kadd_pkg::alu_result_type alu_res;
   logic                       wr_en;
   logic [RB-1:0]              wr_addr;
   logic [DB-1:0]              wr_data;
   logic [47:0]                rsp_data_in;
   logic                       rsp_user_in;

   // Handshake and stage control
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;
   assign rd_addr    = req_tdata[11:9];

   // Operand: forwarded write, RAM data, or reset value
   assign reg_operand = fwd_ff ? fwd_data_ff : (rd_valid_ff ? rd_data_ff : '0);

   m68kadd_alu u_alu (
      .op_word     (s1_op_ff),
      .reg_operand (reg_operand),
      .ea_operand  (s1_ea_ff),
      .ea_cycles   (s1_cyc_ff),
      .result      (alu_res)
   );

   // Write-back select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s1_op_ff[11:9];
      wr_data = alu_res.reg_wdata;
      rsp_data_in = '0;
      rsp_user_in = 1'b0;
      case (s1_kind_ff)
         m68kadd_pkg::KIND_LOAD: begin
            wr_en   = s1_advance;
            wr_addr = s1_lidx_ff;
            wr_data = s1_lval_ff;
         end
         default: begin
            wr_en       = s1_advance && alu_res.reg_write;
            rsp_data_in = {2'b00, alu_res.cycles, alu_res.ccr, alu_res.to_ea, alu_res.sum};
            rsp_user_in = alu_res.performed;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en)
         valid_in[wr_addr] = 1'b1;
   end

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // RAM write and registered read
   always_ff @(posedge clock) begin
      if (wr_en)
         regfile[wr_addr] <= wr_data;
      if (req_fire)
         rd_data_ff <= regfile[rd_addr];
   end

   // Execute stage payload and forwarding capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff  <= m68kadd_pkg::kind_type'(req_tuser);
         s1_op_ff    <= req_tdata[15:0];
         s1_ea_ff    <= req_tdata[47:16];
         s1_cyc_ff   <= req_tdata[55:48];
         s1_lidx_ff  <= req_tdata[58:56];
         s1_lval_ff  <= req_tdata[90:59];
         rd_valid_ff <= valid_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks
   a_write_needs_stage: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_valid_ff)
      else $error("register write without an item in execute");

   a_no_op_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[37:0] == 38'd0))
      else $error("non-ADD result carries sum or flags");

   a_x_equals_c: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[37] == rsp_tdata[33]))
      else $error("X flag differs from C");

   a_add_min_cycles: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[45:38] >= m68kadd_pkg::CYC_LONG_OTHER ||
                                     rsp_tdata[45:38] == m68kadd_pkg::CYC_SHORT_REG ||
                                     rsp_tdata[45:38] == 8'd5))
      else $error("ADD reported fewer than four cycles");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> s1_valid_ff)
      else $error("execute stage dropped a stalled item");

endmodule
